// ===== src/crr_pkg.sv =====
// Shared types and constants for the character rounding upscaler.
`timescale 1ns / 1ps

package crr_pkg;

   // Output line field width and its byte-padded stream width
   localparam int LINE_W     = 12;
   localparam int RSP_DATA_W = 16;

   // Input sideband bit positions
   localparam int USER_W        = 2;
   localparam int USER_FIRST    = 0;
   localparam int USER_ROUNDING = 1;

   // Line selector within one source row
   localparam logic LINE_UPPER = 1'b0;
   localparam logic LINE_LOWER = 1'b1;

   // Control of the line currently offered by the row buffer
   typedef struct packed {
      logic valid;
      logic lower;
      logic last;
      logic rounding;
   } job_ctl_type;

endpackage

// ===== src/crr_line.sv =====
// Combinational builder of one doubled output line with diagonal rounding.
`timescale 1ns / 1ps

module crr_line #(
   parameter int SOURCE_WIDTH = 6
) (
   input  logic [SOURCE_WIDTH-1:0]       up_row,
   input  logic [SOURCE_WIDTH-1:0]       cur_row,
   input  logic [SOURCE_WIDTH-1:0]       down_row,
   input  crr_pkg::job_ctl_type          ctl,
   output logic [crr_pkg::LINE_W-1:0]    line_bits
);

   localparam int WIDE_W = 2 * SOURCE_WIDTH;

   logic [SOURCE_WIDTH+1:0] cur_x;
   logic [SOURCE_WIDTH+1:0] side_x;
   logic [WIDE_W-1:0]       wide;

   // Pad both rows with a clear pixel on each side
   assign cur_x  = {1'b0, cur_row, 1'b0};
   assign side_x = (ctl.lower == crr_pkg::LINE_LOWER) ? {1'b0, down_row, 1'b0}
                                                      : {1'b0, up_row, 1'b0};

   // Fill lit cells, round the corners of clear cells when rounding is on
   always_comb begin
      wide = '0;
      for (int b = 0; b < SOURCE_WIDTH; b++) begin
         if (cur_x[b+1]) begin
            wide[2*b+1] = 1'b1;
            wide[2*b]   = 1'b1;
         end else if (ctl.rounding) begin
            wide[2*b+1] = side_x[b+1] & cur_x[b+2] & ~side_x[b+2];
            wide[2*b]   = side_x[b+1] & cur_x[b]   & ~side_x[b];
         end
      end
   end

   // Fit the line to the output field
   generate
      if (WIDE_W >= crr_pkg::LINE_W) begin : g_trunc
         assign line_bits = wide[crr_pkg::LINE_W-1:0];
      end else begin : g_ext
         assign line_bits = {{(crr_pkg::LINE_W-WIDE_W){1'b0}}, wide};
      end
   endgenerate

endmodule

// ===== src/crr_rows.sv =====
// Row history and two-entry buffer of source rows waiting to be expanded.
`timescale 1ns / 1ps

module crr_rows #(
   parameter int SOURCE_WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [SOURCE_WIDTH-1:0]  in_row,
   input  logic                     in_first,
   input  logic                     in_last,
   input  logic                     in_rounding,
   input  logic                     advance,
   output crr_pkg::job_ctl_type     ctl,
   output logic [SOURCE_WIDTH-1:0]  up_row,
   output logic [SOURCE_WIDTH-1:0]  cur_row,
   output logic [SOURCE_WIDTH-1:0]  down_row
);

   // Character history
   logic [SOURCE_WIDTH-1:0] above_ff, above_in;
   logic [SOURCE_WIDTH-1:0] pend_ff, pend_in;
   logic                    have_ff, have_in;
   logic                    rnd_ff, rnd_in;

   // Row jobs: entry 0 is on the output, entry 1 follows
   logic [SOURCE_WIDTH-1:0] j0_up_ff, j0_up_in, j0_cur_ff, j0_cur_in, j0_dn_ff, j0_dn_in;
   logic [SOURCE_WIDTH-1:0] j1_up_ff, j1_up_in, j1_cur_ff, j1_cur_in, j1_dn_ff, j1_dn_in;
   logic                    j0_valid_ff, j0_valid_in, j1_valid_ff, j1_valid_in;
   logic                    j0_last_ff, j0_last_in, j1_last_ff, j1_last_in;
   logic                    phase_ff, phase_in;
   logic                    job_rnd_ff, job_rnd_in;

   logic                    accept;
   logic [SOURCE_WIDTH-1:0] above0, above1;
   logic                    have0;

   // Take a beat once the buffer drains by the end of this cycle
   assign in_ready = ~j0_valid_ff
                   | (advance & (phase_ff == crr_pkg::LINE_LOWER) & ~j1_valid_ff);
   assign accept   = in_valid & in_ready;

   // Row context after a possible character start
   assign above0 = in_first ? '0 : above_ff;
   assign have0  = in_first ? 1'b0 : have_ff;
   assign above1 = have0 ? pend_ff : above0;

   // Update history and buffer
   always_comb begin
      above_in    = above_ff;
      pend_in     = pend_ff;
      have_in     = have_ff;
      rnd_in      = rnd_ff;
      j0_up_in    = j0_up_ff;
      j0_cur_in   = j0_cur_ff;
      j0_dn_in    = j0_dn_ff;
      j0_last_in  = j0_last_ff;
      j0_valid_in = j0_valid_ff;
      j1_up_in    = j1_up_ff;
      j1_cur_in   = j1_cur_ff;
      j1_dn_in    = j1_dn_ff;
      j1_last_in  = j1_last_ff;
      j1_valid_in = j1_valid_ff;
      phase_in    = phase_ff;
      job_rnd_in  = job_rnd_ff;

      // Advance through the queued lines
      if (advance) begin
         if (phase_ff == crr_pkg::LINE_UPPER) begin
            phase_in = crr_pkg::LINE_LOWER;
         end else begin
            phase_in    = crr_pkg::LINE_UPPER;
            j0_up_in    = j1_up_ff;
            j0_cur_in   = j1_cur_ff;
            j0_dn_in    = j1_dn_ff;
            j0_last_in  = j1_last_ff;
            j0_valid_in = j1_valid_ff;
            j1_valid_in = 1'b0;
         end
      end

      // Load the jobs of a new beat
      if (accept) begin
         rnd_in      = in_first ? in_rounding : rnd_ff;
         job_rnd_in  = rnd_in;
         phase_in    = crr_pkg::LINE_UPPER;
         j1_valid_in = 1'b0;
         j0_valid_in = have0 | in_last;
         if (have0) begin
            j0_up_in   = above0;
            j0_cur_in  = pend_ff;
            j0_dn_in   = in_row;
            j0_last_in = 1'b0;
            j1_up_in   = above1;
            j1_cur_in  = in_row;
            j1_dn_in   = '0;
            j1_last_in = 1'b1;
            j1_valid_in = in_last;
         end else begin
            j0_up_in   = above1;
            j0_cur_in  = in_row;
            j0_dn_in   = '0;
            j0_last_in = 1'b1;
         end
         if (in_last) begin
            above_in = '0;
            pend_in  = '0;
            have_in  = 1'b0;
         end else begin
            above_in = above1;
            pend_in  = in_row;
            have_in  = 1'b1;
         end
      end
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff    <= '0;
         pend_ff     <= '0;
         have_ff     <= 1'b0;
         rnd_ff      <= 1'b0;
         j0_valid_ff <= 1'b0;
         j1_valid_ff <= 1'b0;
         phase_ff    <= crr_pkg::LINE_UPPER;
      end else begin
         above_ff    <= above_in;
         pend_ff     <= pend_in;
         have_ff     <= have_in;
         rnd_ff      <= rnd_in;
         j0_valid_ff <= j0_valid_in;
         j1_valid_ff <= j1_valid_in;
         phase_ff    <= phase_in;
      end
   end

   // Job payload
   always_ff @(posedge clock) begin
      j0_up_ff   <= j0_up_in;
      j0_cur_ff  <= j0_cur_in;
      j0_dn_ff   <= j0_dn_in;
      j0_last_ff <= j0_last_in;
      j1_up_ff   <= j1_up_in;
      j1_cur_ff  <= j1_cur_in;
      j1_dn_ff   <= j1_dn_in;
      j1_last_ff <= j1_last_in;
      job_rnd_ff <= job_rnd_in;
   end

   // Offer the current line
   assign ctl.valid    = j0_valid_ff;
   assign ctl.lower    = phase_ff;
   assign ctl.last     = j0_last_ff & (phase_ff == crr_pkg::LINE_LOWER);
   assign ctl.rounding = job_rnd_ff;
   assign up_row       = j0_up_ff;
   assign cur_row      = j0_cur_ff;
   assign down_row     = j0_dn_ff;

endmodule

// ===== src/font_character_rounding_upscaler.sv =====
// Top level of the character rounding font upscaler.
//
// Usage:
//   The req_ channel takes one source font row per beat: row pixels in
//   req_tdata, the bottom-row mark in req_tlast, and in req_tuser the
//   top-row mark and the rounding enable for the character. The rsp_
//   channel returns doubled output lines, one per beat, with rsp_tlast
//   on the final line of a character.
//   Each row yields two lines, emitted one row late because a row's lower
//   line needs the row below; a bottom row under a held row flushes four
//   lines, a top row that is not also a bottom row yields none.
//   A row's first line passes through the line buffer and the output
//   register after the beat that completes its context. The block gives
//   one output line per cycle while lines are buffered and rsp_tready is
//   high, set by the single line builder feeding the output register.
//   A new row is taken in the cycle its predecessor's last line moves to
//   the output register, so rows follow back to back.
//   Reset clears the row history, the rounding mode and the line buffer.
//   When rsp_tready is low the output register holds its line and the
//   input stalls once the buffered lines cannot drain.
`timescale 1ns / 1ps

module font_character_rounding_upscaler #(
   parameter int SOURCE_WIDTH = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // row_bits
   input  logic [((SOURCE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                 req_tlast,
   // first_row, rounding_on
   input  logic [crr_pkg::USER_W-1:0]           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // line_bits
   output logic [crr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast
);

   crr_pkg::job_ctl_type          ctl;
   logic [SOURCE_WIDTH-1:0]       up_row, cur_row, down_row;
   logic [crr_pkg::LINE_W-1:0]    line;
   logic                          advance;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [crr_pkg::LINE_W-1:0]    rsp_line_ff;
   logic                          rsp_last_ff;

   // Move a line into the output register when it is free
   assign advance = ctl.valid & (~rsp_valid_ff | rsp_tready);

   crr_rows #(
      .SOURCE_WIDTH(SOURCE_WIDTH)
   ) u_rows (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_row      (req_tdata[SOURCE_WIDTH-1:0]),
      .in_first    (req_tuser[crr_pkg::USER_FIRST]),
      .in_last     (req_tlast),
      .in_rounding (req_tuser[crr_pkg::USER_ROUNDING]),
      .advance     (advance),
      .ctl         (ctl),
      .up_row      (up_row),
      .cur_row     (cur_row),
      .down_row    (down_row)
   );

   crr_line #(
      .SOURCE_WIDTH(SOURCE_WIDTH)
   ) u_line (
      .up_row    (up_row),
      .cur_row   (cur_row),
      .down_row  (down_row),
      .ctl       (ctl),
      .line_bits (line)
   );

   // Output valid: load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_line_ff <= line;
         rsp_last_ff <= ctl.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(crr_pkg::RSP_DATA_W-crr_pkg::LINE_W){1'b0}}, rsp_line_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the character rounding font upscaler.
`timescale 1ns / 1ps

module testbench;

   localparam int SRC_W      = 6;
   localparam int REQ_DATA_W = ((SRC_W + 7) / 8) * 8;
   localparam int RANDOM_ROWS = 300;

   // One output line as it leaves the block
   typedef struct packed {
      logic                       last;
      logic [crr_pkg::LINE_W-1:0] bits;
   } line_beat_type;

   // One source row to send; known lines are {line_last, line_bits}, oldest first
   typedef struct packed {
      logic [SRC_W-1:0] row;
      logic             first;
      logic             last;
      logic             rnd;
      logic [2:0]       known_n;
      logic [0:3][12:0] known;
   } font_row_type;

   // Directed rows: rows with known_n = 0 are checked against the predictor
   localparam int DIRECTED_N = 26;
   localparam font_row_type DIRECTED [0:DIRECTED_N-1] = '{
      // single-row characters: all lit, all clear, edge pixels only
      '{6'h3F, 1'b1, 1'b1, 1'b0, 3'd2, '{13'h0FFF, 13'h1FFF, 13'h0000, 13'h0000}},
      '{6'h00, 1'b1, 1'b1, 1'b1, 3'd2, '{13'h0000, 13'h1000, 13'h0000, 13'h0000}},
      '{6'h21, 1'b1, 1'b1, 1'b0, 3'd2, '{13'h0C03, 13'h1C03, 13'h0000, 13'h0000}},
      // character without a top-row mark, flushed by its bottom row
      '{6'h15, 1'b0, 1'b0, 1'b1, 3'd0, '0},
      '{6'h2A, 1'b0, 1'b1, 1'b0, 3'd0, '0},
      // unfinished character cut off by a new top row
      '{6'h3F, 1'b1, 1'b0, 1'b1, 3'd0, '0},
      '{6'h0C, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      // diagonal stroke with rounding
      '{6'h33, 1'b1, 1'b0, 1'b1, 3'd0, '0},
      '{6'h20, 1'b1, 1'b0, 1'b1, 3'd0, '0},
      '{6'h10, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h08, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h04, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h02, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h01, 1'b0, 1'b1, 1'b0, 3'd0, '0},
      // opposite diagonal without rounding
      '{6'h01, 1'b1, 1'b0, 1'b0, 3'd0, '0},
      '{6'h02, 1'b0, 1'b0, 1'b1, 3'd0, '0},
      '{6'h04, 1'b0, 1'b1, 1'b1, 3'd0, '0},
      // opposite diagonal with rounding
      '{6'h01, 1'b1, 1'b0, 1'b1, 3'd0, '0},
      '{6'h02, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h04, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h08, 1'b0, 1'b1, 1'b0, 3'd0, '0},
      // no top-row mark: rounding mode stays latched from the last top row
      '{6'h12, 1'b0, 1'b0, 1'b0, 3'd0, '0},
      '{6'h21, 1'b0, 1'b1, 1'b0, 3'd0, '0},
      '{6'h3F, 1'b0, 1'b1, 1'b1, 3'd0, '0},
      '{6'h00, 1'b1, 1'b0, 1'b0, 3'd0, '0},
      '{6'h3F, 1'b0, 1'b1, 1'b0, 3'd0, '0}
   };

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [REQ_DATA_W-1:0]          req_tdata  = '0;   // row_bits
   logic                           req_tlast  = 1'b0;
   logic [crr_pkg::USER_W-1:0]     req_tuser  = '0;   // first_row, rounding_on
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [crr_pkg::RSP_DATA_W-1:0] rsp_tdata;          // line_bits
   logic                           rsp_tlast;

   // Predictor state
   logic [SRC_W-1:0] prev_row;
   logic [SRC_W-1:0] held_row;
   logic             row_held;
   logic             round_mode;

   line_beat_type expected_lines [$];
   line_beat_type oldest_line;
   int            mismatches = 0;
   logic          steady     = 1'b0;

   font_character_rounding_upscaler #(
      .SOURCE_WIDTH(SRC_W)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Pixel lookup; pixels outside the row are clear
   function automatic logic pixel_at(input logic [SRC_W-1:0] row, input int pos);
      if (pos < 0 || pos >= SRC_W) return 1'b0;
      return row[pos];
   endfunction

   // Build one doubled line of cur; side is the row above or below it
   function automatic logic [crr_pkg::LINE_W-1:0] build_line(
         input logic [SRC_W-1:0] side,
         input logic [SRC_W-1:0] cur,
         input logic rnd);
      logic [crr_pkg::LINE_W-1:0] line;
      logic                       lft;
      logic                       rgt;
      line = '0;
      for (int b = 0; b < SRC_W; b++) begin
         lft = cur[b];
         rgt = cur[b];
         // round a clear pixel toward a lit corner with a clear diagonal
         if (!cur[b] && rnd) begin
            if (pixel_at(side, b) && pixel_at(cur, b + 1) && !pixel_at(side, b + 1))
               lft = 1'b1;
            if (pixel_at(side, b) && pixel_at(cur, b - 1) && !pixel_at(side, b - 1))
               rgt = 1'b1;
         end
         line[2*b+1] = lft;
         line[2*b]   = rgt;
      end
      return line;
   endfunction

   // Advance the predictor by one source row and queue the lines it releases
   task automatic upscale_row(input font_row_type s);
      line_beat_type lines [4];
      int            n;
      n = 0;
      if (s.first) begin
         prev_row   = '0;
         row_held   = 1'b0;
         round_mode = s.rnd;
      end
      // release the held row now that the row below is known
      if (row_held) begin
         lines[0] = {1'b0, build_line(prev_row, held_row, round_mode)};
         lines[1] = {1'b0, build_line(s.row, held_row, round_mode)};
         n = 2;
         prev_row = held_row;
      end
      held_row = s.row;
      row_held = 1'b1;
      // flush the bottom row against a clear row below
      if (s.last) begin
         lines[n]   = {1'b0, build_line(prev_row, held_row, round_mode)};
         lines[n+1] = {1'b1, build_line('0, held_row, round_mode)};
         n = n + 2;
         prev_row = '0;
         held_row = '0;
         row_held = 1'b0;
      end
      if (s.known_n != 0) begin
         for (int i = 0; i < s.known_n; i++)
            expected_lines.push_back(line_beat_type'(s.known[i]));
      end else begin
         for (int i = 0; i < n; i++) expected_lines.push_back(lines[i]);
      end
   endtask

   // Offer one row beat, after a random gap outside the steady phase; called and returns at a falling edge
   task automatic send_row(input font_row_type s);
      logic [crr_pkg::USER_W-1:0] user;
      user                         = '0;
      user[crr_pkg::USER_FIRST]    = s.first;
      user[crr_pkg::USER_ROUNDING] = s.rnd;
      while (!steady && $urandom_range(0, 99) < 38) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(s.row);
      req_tlast  <= s.last;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      upscale_row(s);
      @(negedge clock);
   endtask

   // Stall the result side at random, outside the steady phase
   always @(negedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 38);
   end

   // Check each line beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lines.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected line: bits=%h last=%b",
                        rsp_tdata[crr_pkg::LINE_W-1:0], rsp_tlast);
            mismatches++;
         end else begin
            oldest_line = expected_lines.pop_front();
            if (rsp_tdata[crr_pkg::LINE_W-1:0] !== oldest_line.bits ||
                rsp_tlast !== oldest_line.last) begin
               if (mismatches < 10)
                  $display("line mismatch: expected bits=%h last=%b, got bits=%h last=%b",
                           oldest_line.bits, oldest_line.last,
                           rsp_tdata[crr_pkg::LINE_W-1:0], rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      font_row_type s;
      logic [SRC_W-1:0] row;
      int   sent;
      int   len;
      logic noisy;
      logic rnd_char;
      logic drained;
      sent     = 0;
      drained  = 1'b0;
      prev_row = '0;
      held_row = '0;
      row_held = 1'b0;
      round_mode = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_N; i++) send_row(DIRECTED[i]);

      // random characters, mostly well formed, some with stray marks
      while (sent < RANDOM_ROWS) begin
         len      = $urandom_range(1, 8);
         noisy    = ($urandom_range(0, 99) < 20);
         rnd_char = 1'($urandom_range(0, 1));
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 2))
               0: row = SRC_W'($urandom);
               1: row = SRC_W'($urandom & $urandom);
               default: row = SRC_W'($urandom | $urandom);
            endcase
            s     = '0;
            s.row = row;
            if (noisy) begin
               s.first = ($urandom_range(0, 9) == 0);
               s.last  = ($urandom_range(0, 6) == 0);
               s.rnd   = 1'($urandom_range(0, 1));
            end else begin
               s.first = (i == 0);
               s.last  = (i == len - 1);
               s.rnd   = (i == 0) ? rnd_char : 1'($urandom_range(0, 1));
            end
            steady = (sent >= 150 && sent < 230);
            send_row(s);
            sent++;
         end
         // hold off once until every queued line has drained
         if (!drained && sent >= 100) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            while (expected_lines.size() != 0) @(negedge clock);
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (expected_lines.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_lines.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
